// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/adsr_pkg.sv =====
// types, codes and tables of the adsr envelope generator
`default_nettype none
package adsr_pkg;

  localparam int unsigned CNT_W   = 15;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned DIV_W   = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hff;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CTRL = 2'd1,
    REQ_AD   = 2'd2,
    REQ_SR   = 2'd3
  } req_type_t;

  // phase codes as seen on the result channel
  localparam logic [1:0] PHASE_CODE_ATTACK  = 2'd0;
  localparam logic [1:0] PHASE_CODE_DECAY   = 2'd1;
  localparam logic [1:0] PHASE_CODE_SUSTAIN = 2'd2;
  localparam logic [1:0] PHASE_CODE_RELEASE = 2'd3;

  typedef enum logic [3:0] {
    PH_ATTACK  = 4'b0001,
    PH_DECAY   = 4'b0010,
    PH_SUSTAIN = 4'b0100,
    PH_RELEASE = 4'b1000
  } phase_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  envelope_level;
    logic [1:0]  envelope_phase;
  } out_item_t;

  // rate periods in counter ticks
  function automatic logic [CNT_W-1:0] period_lookup(input logic [3:0] sel);
    logic [CNT_W-1:0] p;
    begin
      case (sel)
        4'd0:    p = 15'd8;
        4'd1:    p = 15'd32;
        4'd2:    p = 15'd63;
        4'd3:    p = 15'd95;
        4'd4:    p = 15'd150;
        4'd5:    p = 15'd220;
        4'd6:    p = 15'd267;
        4'd7:    p = 15'd314;
        4'd8:    p = 15'd393;
        4'd9:    p = 15'd942;
        4'd10:   p = 15'd1961;
        4'd11:   p = 15'd3138;
        4'd12:   p = 15'd3922;
        4'd13:   p = 15'd11765;
        4'd14:   p = 15'd19608;
        default: p = 15'd31373;
      endcase
      return p;
    end
  endfunction

  // divider period, longer as the level approaches zero
  function automatic logic [DIV_W-1:0] exp_period(input logic [LEVEL_W-1:0] lv);
    logic [DIV_W-1:0] p;
    begin
      case (lv) inside
        [8'd94:8'd255]: p = 5'd1;
        [8'd55:8'd93]:  p = 5'd2;
        [8'd27:8'd54]:  p = 5'd4;
        [8'd15:8'd26]:  p = 5'd8;
        [8'd7:8'd14]:   p = 5'd16;
        [8'd1:8'd6]:    p = 5'd30;
        default:        p = 5'd1;
      endcase
      return p;
    end
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    begin
      case (ph)
        PH_ATTACK:  c = PHASE_CODE_ATTACK;
        PH_DECAY:   c = PHASE_CODE_DECAY;
        PH_SUSTAIN: c = PHASE_CODE_SUSTAIN;
        default:    c = PHASE_CODE_RELEASE;
      endcase
      return c;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/adsr_envelope_generator_unit.sv =====
// top level of the adsr envelope generator: input stage, update logic, result register
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | in_data  (req_type, write_data)
//   out     | out_valid / out_ready| out_data (envelope_level, envelope_phase)
//
// one item per cycle sustained while the output is drained
// the input register feeds the state update, whose result lands in the output register
// rst (synchronous) empties both stages and loads the release phase at level zero
// a stalled output holds its result; the input stage keeps one more item meanwhile
`default_nettype none
module adsr_envelope_generator_unit
  import adsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  out_item_t result;

  // the update stage moves whenever the output register is free or being drained
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  adsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== sv/adsr_core.sv =====
// envelope state and the per-item update logic
`default_nettype none
module adsr_core
  import adsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic [CNT_W-1:0]   rate_counter, rate_counter_next;
  phase_t             phase, phase_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic               floor_hold, floor_hold_next;
  logic [DIV_W-1:0]   exp_divider, exp_divider_next;
  logic [CNT_W-1:0]   attack_threshold, attack_threshold_next;
  logic [CNT_W-1:0]   decay_threshold, decay_threshold_next;
  logic [CNT_W-1:0]   release_threshold, release_threshold_next;
  logic [LEVEL_W-1:0] sustain_level, sustain_level_next;
  logic               gate_bit, gate_bit_next;

  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   active_thr;
  logic               thr_match;
  logic [DIV_W-1:0]   div_inc;
  logic               div_fires;
  logic [LEVEL_W-1:0] level_up;

  always_comb begin
    cnt_inc   = rate_counter + 1'b1;
    case (phase)
      PH_ATTACK:  active_thr = attack_threshold;
      PH_DECAY:   active_thr = decay_threshold;
      PH_SUSTAIN: active_thr = decay_threshold;
      default:    active_thr = release_threshold;
    endcase
    thr_match = (cnt_inc == active_thr);
    div_inc   = exp_divider + 1'b1;
    div_fires = (div_inc >= exp_period(level));
    level_up  = (level != LEVEL_MAX) ? level + 1'b1 : level;
  end

  always_comb begin
    rate_counter_next      = rate_counter;
    phase_next             = phase;
    level_next             = level;
    floor_hold_next        = floor_hold;
    exp_divider_next       = exp_divider;
    attack_threshold_next  = attack_threshold;
    decay_threshold_next   = decay_threshold;
    release_threshold_next = release_threshold;
    sustain_level_next     = sustain_level;
    gate_bit_next          = gate_bit;

    case (item.req_type)
      REQ_TICK: begin
        rate_counter_next = thr_match ? '0 : cnt_inc;
        case (phase)
          PH_ATTACK: begin
            if (thr_match && !floor_hold) begin
              level_next       = level_up;
              exp_divider_next = '0;
              if (level_up == LEVEL_MAX) begin
                phase_next = PH_DECAY;
              end
            end
          end
          PH_DECAY: begin
            if (thr_match) begin
              exp_divider_next = div_fires ? '0 : div_inc;
              if (div_fires && !floor_hold) begin
                if (level != sustain_level) begin
                  level_next = level - 1'b1;
                end else begin
                  phase_next = PH_SUSTAIN;
                end
              end
            end
          end
          PH_SUSTAIN: begin
            if (level > sustain_level) begin
              phase_next = PH_DECAY;
            end
          end
          default: begin
            // release has no floor: an unlocked step at zero wraps to full scale
            if (thr_match) begin
              exp_divider_next = div_fires ? '0 : div_inc;
              if (div_fires && !floor_hold) begin
                level_next = level - 1'b1;
              end
            end
          end
        endcase
        if (level_next == '0 && level != '0) begin
          floor_hold_next = 1'b1;
        end
      end
      REQ_CTRL: begin
        gate_bit_next = item.write_data[0];
        if (!gate_bit && item.write_data[0]) begin
          phase_next      = PH_ATTACK;
          floor_hold_next = 1'b0;
        end else if (gate_bit && !item.write_data[0]) begin
          phase_next = PH_RELEASE;
        end
      end
      REQ_AD: begin
        attack_threshold_next = period_lookup(item.write_data[7:4]);
        decay_threshold_next  = period_lookup(item.write_data[3:0]);
      end
      default: begin
        sustain_level_next     = {item.write_data[7:4], item.write_data[7:4]};
        release_threshold_next = period_lookup(item.write_data[3:0]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_counter      <= '0;
      phase             <= PH_RELEASE;
      level             <= '0;
      floor_hold        <= 1'b1;
      exp_divider       <= '0;
      attack_threshold  <= '0;
      decay_threshold   <= '0;
      release_threshold <= '0;
      sustain_level     <= '0;
      gate_bit          <= 1'b0;
    end else if (step) begin
      rate_counter      <= rate_counter_next;
      phase             <= phase_next;
      level             <= level_next;
      floor_hold        <= floor_hold_next;
      exp_divider       <= exp_divider_next;
      attack_threshold  <= attack_threshold_next;
      decay_threshold   <= decay_threshold_next;
      release_threshold <= release_threshold_next;
      sustain_level     <= sustain_level_next;
      gate_bit          <= gate_bit_next;
    end
  end

  assign result.envelope_level = level_next;
  assign result.envelope_phase = phase_code(phase_next);

endmodule
`default_nettype wire

// ===== sv/adsr_checker.sv =====
// port-level checks of the adsr envelope generator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module adsr_checker
  import adsr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `ASSERT_CLK(a_reset_empties_output, clk, rst |=> !out_valid, "result valid after reset")
  `ASSERT_CLK_RST(a_free_output_takes_input, clk, rst, !out_valid |-> in_ready, "input stalled with free output")
  `ASSERT_CLK_RST(a_stall_holds_result, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  // consecutive results differ in level by at most one step, wrap included
  `ASSERT_CLK_RST(a_level_single_step, clk, rst, out_valid && out_ready |=> !out_valid || (8'(out_data.envelope_level - $past(out_data.envelope_level)) == 8'd0) || (8'(out_data.envelope_level - $past(out_data.envelope_level)) == 8'd1) || (8'(out_data.envelope_level - $past(out_data.envelope_level)) == 8'hff), "level jumped")

endmodule

bind adsr_envelope_generator_unit adsr_checker u_adsr_checker (.*);
`default_nettype wire
